// ===== src/ipv4_route_table_core_macros.svh =====
// Assertion macros used by the route table core RTL.
`ifndef IPV4_ROUTE_TABLE_CORE_MACROS_SVH
`define IPV4_ROUTE_TABLE_CORE_MACROS_SVH

// checked outside reset only
`define IPRT_ASSERT(lbl, clk, rst, prop, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// checked on every edge, reset included
`define IPRT_ASSERT_ALWAYS(lbl, clk, prop, msg) \
   lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

// ===== src/iprt_pkg.sv =====
// Types and constants of the IPv4 route table.
`timescale 1ns / 1ps

package iprt_pkg;

   localparam int DEF_ROUTE_SLOTS = 16;
   localparam int DEF_IFACE_BITS  = 4;
   localparam int DEF_REF_BITS    = 8;

   localparam int ADDR_BITS  = 32;
   localparam int FIELD4_BITS = 4;

   typedef enum logic [1:0] {
      OP_LOOKUP      = 2'd0,
      OP_ADD_ROUTE   = 2'd1,
      OP_ADD_DEFAULT = 2'd2,
      OP_RELEASE     = 2'd3
   } op_type;

   typedef enum logic [1:0] {
      STAT_OK      = 2'd0,
      STAT_FULL    = 2'd1,
      STAT_NOROUTE = 2'd2,
      STAT_UNREF   = 2'd3
   } status_type;

   typedef enum logic [2:0] {
      S_IDLE,
      S_SCAN,
      S_ADD,
      S_REL,
      S_REF_RD,
      S_REF_UPD
   } state_type;

endpackage

// ===== src/iprt_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
`timescale 1ns / 1ps

module iprt_ram
   import iprt_pkg::*;
#(
   parameter int WIDTH = 8,
   parameter int DEPTH = DEF_ROUTE_SLOTS
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

// ===== src/ipv4_route_table_core.sv =====
// IPv4 first-match route table: add, lookup and reference release under one sequencer.
`timescale 1ns / 1ps

// One operation at a time: start is taken while busy is low, and the result is
// strobed on rsp_valid for a single cycle, which the receiver must take then.
// Slots fill in order and are never freed, so a fill count stands in for the
// per-entry up bits and no clearing pass is needed after reset. Lookup walks
// the filled slots one per cycle through the entry RAM's single read port and
// one masked compare, and stops early when a route hits; the reference count
// update is a read and a write of the count RAM. A release of an unfilled
// slot answers without the count update.
module ipv4_route_table_core
   import iprt_pkg::*;
#(
   parameter int ROUTE_SLOTS = DEF_ROUTE_SLOTS,
   parameter int IFACE_BITS  = DEF_IFACE_BITS,
   parameter int REF_BITS    = DEF_REF_BITS
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        start,
   output logic        busy,
   input  logic [1:0]  req_op,
   input  logic [31:0] req_dest_addr,
   input  logic [31:0] req_net_mask,
   input  logic [3:0]  req_iface_id,
   input  logic [3:0]  req_slot_in,
   output logic        rsp_valid,
   output logic [1:0]  rsp_status,
   output logic [3:0]  rsp_slot_out,
   output logic [3:0]  rsp_iface_out,
   output logic        rsp_hit_default
);

   localparam int SLOT_BITS = $clog2(ROUTE_SLOTS);
   localparam int CNT_BITS  = $clog2(ROUTE_SLOTS + 1);
   localparam int ENT_W     = 1 + IFACE_BITS + 2 * ADDR_BITS;
   localparam int XW        = CNT_BITS + FIELD4_BITS;

   localparam logic [CNT_BITS-1:0] CNT_ONE  = CNT_BITS'(1);
   localparam logic [CNT_BITS-1:0] CNT_FULL = CNT_BITS'(ROUTE_SLOTS);
   localparam logic [REF_BITS-1:0] REF_ONE  = REF_BITS'(1);
   localparam logic [REF_BITS-1:0] REF_MAX  = '1;

   state_type state_ff, state_in;
   logic [CNT_BITS-1:0] fill_ff, fill_in;
   op_type op_ff, op_in;
   logic [31:0] dest_ff, dest_in;
   logic [31:0] mask_ff, mask_in;
   logic [IFACE_BITS-1:0] ifc_ff, ifc_in;
   logic [3:0] slot_ff, slot_in;

   // scan pointer and the slot whose entry is on the RAM output
   logic [CNT_BITS-1:0] idx_ff, idx_in;
   logic rv_ff, rv_in;
   logic [SLOT_BITS-1:0] rslot_ff, rslot_in;

   // latest default seen
   logic dv_ff, dv_in;
   logic [SLOT_BITS-1:0] dslot_ff, dslot_in;
   logic [IFACE_BITS-1:0] diface_ff, diface_in;

   // chosen slot for the count update
   logic [SLOT_BITS-1:0] tgt_ff, tgt_in;
   logic [IFACE_BITS-1:0] hif_ff, hif_in;
   logic hd_ff, hd_in;

   logic rsp_valid_ff, rsp_valid_in;
   status_type rsp_status_ff, rsp_status_in;
   logic [3:0] rsp_slot_ff, rsp_slot_in;
   logic [3:0] rsp_iface_ff, rsp_iface_in;
   logic rsp_hd_ff, rsp_hd_in;

   // RAM ports
   logic ent_we;
   logic [SLOT_BITS-1:0] ent_waddr, ent_raddr;
   logic [ENT_W-1:0] ent_wdata, ent_rdata;
   logic ref_we;
   logic [SLOT_BITS-1:0] ref_waddr;
   logic [REF_BITS-1:0] ref_wdata, ref_rdata;

   logic [31:0] e_dest, e_mask;
   logic [IFACE_BITS-1:0] e_iface;
   logic e_dflt;
   logic e_match;
   logic issue;
   logic [XW-1:0] slot_x, fill_x, req_slot_x;
   logic [IFACE_BITS+3:0] req_ifc_x;

   assign e_dest  = ent_rdata[ADDR_BITS-1:0];
   assign e_mask  = ent_rdata[2*ADDR_BITS-1:ADDR_BITS];
   assign e_iface = ent_rdata[2*ADDR_BITS +: IFACE_BITS];
   assign e_dflt  = ent_rdata[ENT_W-1];
   assign e_match = ((dest_ff & e_mask) == e_dest) && !e_dflt;

   assign issue      = idx_ff < fill_ff;
   assign slot_x     = {{CNT_BITS{1'b0}}, slot_ff};
   assign req_slot_x = {{CNT_BITS{1'b0}}, req_slot_in};
   assign fill_x     = {{FIELD4_BITS{1'b0}}, fill_ff};
   assign req_ifc_x  = {{IFACE_BITS{1'b0}}, req_iface_id};

   assign ent_raddr = idx_ff[SLOT_BITS-1:0];
   assign ent_we    = (state_ff == S_ADD) && (fill_ff != CNT_FULL);
   assign ent_waddr = fill_ff[SLOT_BITS-1:0];
   assign ent_wdata = {op_ff == OP_ADD_DEFAULT, ifc_ff,
                       (op_ff == OP_ADD_ROUTE) ? mask_ff : 32'd0, dest_ff};

   function automatic logic [3:0] low4(input logic [SLOT_BITS-1:0] s);
      logic [SLOT_BITS+3:0] w;
      w = {4'd0, s};
      return w[3:0];
   endfunction

   function automatic logic [3:0] iface4(input logic [IFACE_BITS-1:0] f);
      logic [IFACE_BITS+3:0] w;
      w = {4'd0, f};
      return w[3:0];
   endfunction

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         fill_ff      <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         fill_ff      <= fill_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      op_ff         <= op_in;
      dest_ff       <= dest_in;
      mask_ff       <= mask_in;
      ifc_ff        <= ifc_in;
      slot_ff       <= slot_in;
      idx_ff        <= idx_in;
      rv_ff         <= rv_in;
      rslot_ff      <= rslot_in;
      dv_ff         <= dv_in;
      dslot_ff      <= dslot_in;
      diface_ff     <= diface_in;
      tgt_ff        <= tgt_in;
      hif_ff        <= hif_in;
      hd_ff         <= hd_in;
      rsp_status_ff <= rsp_status_in;
      rsp_slot_ff   <= rsp_slot_in;
      rsp_iface_ff  <= rsp_iface_in;
      rsp_hd_ff     <= rsp_hd_in;
   end

   always_comb begin
      state_in      = state_ff;
      fill_in       = fill_ff;
      op_in         = op_ff;
      dest_in       = dest_ff;
      mask_in       = mask_ff;
      ifc_in        = ifc_ff;
      slot_in       = slot_ff;
      idx_in        = idx_ff;
      rv_in         = rv_ff;
      rslot_in      = rslot_ff;
      dv_in         = dv_ff;
      dslot_in      = dslot_ff;
      diface_in     = diface_ff;
      tgt_in        = tgt_ff;
      hif_in        = hif_ff;
      hd_in         = hd_ff;
      rsp_valid_in  = 1'b0;
      rsp_status_in = rsp_status_ff;
      rsp_slot_in   = rsp_slot_ff;
      rsp_iface_in  = rsp_iface_ff;
      rsp_hd_in     = rsp_hd_ff;
      ref_we        = 1'b0;
      ref_waddr     = tgt_ff;
      ref_wdata     = '0;

      case (state_ff)
         S_IDLE: begin
            if (start) begin
               op_in      = op_type'(req_op);
               dest_in    = req_dest_addr;
               mask_in    = req_net_mask;
               ifc_in     = req_ifc_x[IFACE_BITS-1:0];
               slot_in    = req_slot_in;
               tgt_in     = req_slot_x[SLOT_BITS-1:0];
               idx_in     = '0;
               rv_in      = 1'b0;
               dv_in      = 1'b0;
               case (op_type'(req_op))
                  OP_LOOKUP:                    state_in = S_SCAN;
                  OP_ADD_ROUTE, OP_ADD_DEFAULT: state_in = S_ADD;
                  OP_RELEASE:                   state_in = S_REL;
                  default:                      state_in = S_IDLE;
               endcase
            end
         end

         S_ADD: begin
            rsp_valid_in = 1'b1;
            rsp_iface_in = 4'd0;
            rsp_hd_in    = 1'b0;
            state_in     = S_IDLE;
            if (fill_ff == CNT_FULL) begin
               rsp_status_in = STAT_FULL;
               rsp_slot_in   = 4'd0;
            end else begin
               // a new slot starts with no references
               ref_we        = 1'b1;
               ref_waddr     = fill_ff[SLOT_BITS-1:0];
               ref_wdata     = '0;
               fill_in       = fill_ff + CNT_ONE;
               rsp_status_in = STAT_OK;
               rsp_slot_in   = low4(fill_ff[SLOT_BITS-1:0]);
            end
         end

         S_REL: begin
            if (slot_x >= fill_x) begin
               rsp_valid_in  = 1'b1;
               rsp_status_in = STAT_UNREF;
               rsp_slot_in   = slot_ff;
               rsp_iface_in  = 4'd0;
               rsp_hd_in     = 1'b0;
               state_in      = S_IDLE;
            end else begin
               state_in = S_REF_RD;
            end
         end

         S_SCAN: begin
            rv_in    = issue;
            rslot_in = idx_ff[SLOT_BITS-1:0];
            if (issue) begin
               idx_in = idx_ff + CNT_ONE;
            end
            if (rv_ff && e_match) begin
               tgt_in   = rslot_ff;
               hif_in   = e_iface;
               hd_in    = 1'b0;
               state_in = S_REF_RD;
            end else begin
               if (rv_ff && e_dflt) begin
                  dv_in     = 1'b1;
                  dslot_in  = rslot_ff;
                  diface_in = e_iface;
               end
               // nothing in flight and nothing left to issue: scan over
               if (!rv_ff && !issue) begin
                  if (dv_ff) begin
                     tgt_in   = dslot_ff;
                     hif_in   = diface_ff;
                     hd_in    = 1'b1;
                     state_in = S_REF_RD;
                  end else begin
                     rsp_valid_in  = 1'b1;
                     rsp_status_in = STAT_NOROUTE;
                     rsp_slot_in   = 4'd0;
                     rsp_iface_in  = 4'd0;
                     rsp_hd_in     = 1'b0;
                     state_in      = S_IDLE;
                  end
               end
            end
         end

         S_REF_RD: begin
            state_in = S_REF_UPD;
         end

         S_REF_UPD: begin
            rsp_valid_in = 1'b1;
            state_in     = S_IDLE;
            ref_waddr    = tgt_ff;
            if (op_ff == OP_LOOKUP) begin
               ref_we        = 1'b1;
               ref_wdata     = (ref_rdata == REF_MAX) ? ref_rdata : ref_rdata + REF_ONE;
               rsp_status_in = STAT_OK;
               rsp_slot_in   = low4(tgt_ff);
               rsp_iface_in  = iface4(hif_ff);
               rsp_hd_in     = hd_ff;
            end else begin
               rsp_slot_in  = slot_ff;
               rsp_iface_in = 4'd0;
               rsp_hd_in    = 1'b0;
               if (ref_rdata == '0) begin
                  rsp_status_in = STAT_UNREF;
               end else begin
                  ref_we        = 1'b1;
                  ref_wdata     = ref_rdata - REF_ONE;
                  rsp_status_in = STAT_OK;
               end
            end
         end

         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   iprt_ram #(
      .WIDTH (ENT_W),
      .DEPTH (ROUTE_SLOTS)
   ) u_entry_ram (
      .clock   (clock),
      .wr_en   (ent_we),
      .wr_addr (ent_waddr),
      .wr_data (ent_wdata),
      .rd_addr (ent_raddr),
      .rd_data (ent_rdata)
   );

   iprt_ram #(
      .WIDTH (REF_BITS),
      .DEPTH (ROUTE_SLOTS)
   ) u_ref_ram (
      .clock   (clock),
      .wr_en   (ref_we),
      .wr_addr (ref_waddr),
      .wr_data (ref_wdata),
      .rd_addr (tgt_ff),
      .rd_data (ref_rdata)
   );

   assign busy            = (state_ff != S_IDLE);
   assign rsp_valid       = rsp_valid_ff;
   assign rsp_status      = rsp_status_ff;
   assign rsp_slot_out    = rsp_slot_ff;
   assign rsp_iface_out   = rsp_iface_ff;
   assign rsp_hit_default = rsp_hd_ff;

`include "ipv4_route_table_core_macros.svh"

   `IPRT_ASSERT_ALWAYS(a_reset_idle, clock, reset |=> !busy && !rsp_valid, "not idle after reset")
   `IPRT_ASSERT(a_accept_busy, clock, reset, start && !busy |=> busy,
                "accepted beat did not go busy")
   `IPRT_ASSERT(a_single_strobe, clock, reset, rsp_valid |=> !rsp_valid, "result strobe held")
   `IPRT_ASSERT(a_fill_bound, clock, reset, fill_ff <= CNT_FULL, "fill count beyond table size")
   `IPRT_ASSERT(a_full_only_when_full, clock, reset,
                rsp_valid && rsp_status == STAT_FULL |-> fill_ff == CNT_FULL,
                "table full reported with free slots")

endmodule

// ===== tb/ipv4_route_table_core_test.sv =====
// Self-checking testbench for the IPv4 first-match route table core.
`timescale 1ns / 1ps

module ipv4_route_table_core_test;
   import iprt_pkg::*;

   localparam int SLOTS       = DEF_ROUTE_SLOTS;
   localparam int REF_MAX     = (1 << DEF_REF_BITS) - 1;
   localparam int DIR_ROWS    = 20;
   localparam int RAND_ITEMS  = 700;
   localparam int QUIET_ITEMS = 100;
   localparam int HOT_FIRST   = 140;
   localparam int HOT_LAST    = 440;
   localparam int TAIL_CYCLES = 40;
   localparam int CYCLE_LIMIT = 300000;

   typedef struct packed {
      status_type status;
      logic [3:0] slot;
      logic [3:0] iface;
      logic       dflt;
   } route_rsp_type;

   typedef struct packed {
      op_type        op;
      logic [31:0]   addr;
      logic [31:0]   mask;
      logic [3:0]    iface;
      logic [3:0]    slot;
      logic          pinned;
      route_rsp_type want;
   } route_cmd_type;

   localparam route_rsp_type NO_PIN = '{STAT_OK, 4'd0, 4'd0, 1'b0};

   logic        clock;
   logic        reset;
   logic        start;
   logic        busy;
   logic [1:0]  req_op;
   logic [31:0] req_dest_addr;
   logic [31:0] req_net_mask;
   logic [3:0]  req_iface_id;
   logic [3:0]  req_slot_in;
   logic        rsp_valid;
   logic [1:0]  rsp_status;
   logic [3:0]  rsp_slot_out;
   logic [3:0]  rsp_iface_out;
   logic        rsp_hit_default;

   // expectation pinned to the beat on the request ports, if any
   logic          pin_valid;
   route_rsp_type pin_rsp;

   // shadow copy of the route table
   logic                    tbl_up    [SLOTS];
   logic                    tbl_dflt  [SLOTS];
   logic [31:0]             tbl_dest  [SLOTS];
   logic [31:0]             tbl_mask  [SLOTS];
   logic [3:0]              tbl_iface [SLOTS];
   logic [DEF_REF_BITS-1:0] tbl_refs  [SLOTS];

   route_rsp_type pending_rsp_q [$];
   route_cmd_type dir_tab [DIR_ROWS];
   int         mismatch_cnt = 0;
   int         cycle_cnt = 0;
   logic [31:0] hot_addr;
   int          hot_slot;

   ipv4_route_table_core i_dut (
      .clock           (clock),
      .reset           (reset),
      .start           (start),
      .busy            (busy),
      .req_op          (req_op),
      .req_dest_addr   (req_dest_addr),
      .req_net_mask    (req_net_mask),
      .req_iface_id    (req_iface_id),
      .req_slot_in     (req_slot_in),
      .rsp_valid       (rsp_valid),
      .rsp_status      (rsp_status),
      .rsp_slot_out    (rsp_slot_out),
      .rsp_iface_out   (rsp_iface_out),
      .rsp_hit_default (rsp_hit_default)
   );

   always begin
      clock = 1'b0;
      #10;
      clock = 1'b1;
      #10;
   end

   // Applies one operation to the shadow table and returns the result it gives.
   function automatic route_rsp_type route_table_apply(op_type op, logic [31:0] addr,
         logic [31:0] mask, logic [3:0] iface, logic [3:0] slot);
      route_rsp_type r;
      int hit;
      int fallback;
      int free_idx;
      r = NO_PIN;
      case (op)
         OP_LOOKUP: begin
            hit = -1;
            fallback = -1;
            for (int i = 0; i < SLOTS; i++) begin
               if (tbl_up[i] && hit < 0) begin
                  if (tbl_dflt[i])
                     fallback = i;
                  else if ((addr & tbl_mask[i]) == tbl_dest[i])
                     hit = i;
               end
            end
            if (hit < 0)
               hit = fallback;
            if (hit < 0) begin
               r.status = STAT_NOROUTE;
            end else begin
               if (tbl_refs[hit] != REF_MAX)
                  tbl_refs[hit] = tbl_refs[hit] + 1'b1;
               r.slot  = 4'(hit);
               r.iface = tbl_iface[hit];
               r.dflt  = tbl_dflt[hit];
            end
         end
         OP_ADD_ROUTE, OP_ADD_DEFAULT: begin
            free_idx = -1;
            for (int i = 0; i < SLOTS; i++)
               if (free_idx < 0 && !tbl_up[i] && !tbl_dflt[i] && tbl_refs[i] == 0)
                  free_idx = i;
            if (free_idx < 0) begin
               r.status = STAT_FULL;
            end else begin
               tbl_up[free_idx]    = 1'b1;
               tbl_dflt[free_idx]  = (op == OP_ADD_DEFAULT);
               tbl_dest[free_idx]  = addr;
               tbl_mask[free_idx]  = (op == OP_ADD_ROUTE) ? mask : 32'h0;
               tbl_iface[free_idx] = iface;
               tbl_refs[free_idx]  = '0;
               r.slot = 4'(free_idx);
            end
         end
         default: begin
            r.slot = slot;
            if (tbl_refs[slot] == 0)
               r.status = STAT_UNREF;
            else
               tbl_refs[slot] = tbl_refs[slot] - 1'b1;
         end
      endcase
      return r;
   endfunction

   task automatic report_mismatch(input string what, input int unsigned got_v,
         input int unsigned exp_v);
      mismatch_cnt++;
      if (mismatch_cnt <= 50)
         $display("MISMATCH %s: got %0h expected %0h (cycle %0d)", what, got_v, exp_v,
                  cycle_cnt);
   endtask

   // prediction at accept, checking at strobe: one process, so order is fixed
   always @(posedge clock) begin
      route_rsp_type want;
      if (!reset) begin
         if (start && !busy) begin
            want = route_table_apply(op_type'(req_op), req_dest_addr, req_net_mask,
                                     req_iface_id, req_slot_in);
            if (pin_valid)
               want = pin_rsp;
            pending_rsp_q.push_back(want);
         end
         if (rsp_valid) begin
            if (pending_rsp_q.size() == 0) begin
               report_mismatch("result with nothing pending, status", rsp_status, 0);
            end else begin
               want = pending_rsp_q.pop_front();
               if (rsp_status != want.status)
                  report_mismatch("status", rsp_status, want.status);
               if (rsp_slot_out != want.slot)
                  report_mismatch("slot_out", rsp_slot_out, want.slot);
               if (rsp_iface_out != want.iface)
                  report_mismatch("iface_out", rsp_iface_out, want.iface);
               if (rsp_hit_default != want.dflt)
                  report_mismatch("hit_default", rsp_hit_default, want.dflt);
            end
         end
      end
   end

   always @(posedge clock) begin
      cycle_cnt++;
      if (cycle_cnt > CYCLE_LIMIT) begin
         $display("Simulation FAILED");
         $finish;
      end
   end

   // mostly an address under a stored route, host bits random
   function automatic logic [31:0] pick_lookup_addr();
      int k;
      k = $urandom_range(0, SLOTS - 1);
      if ($urandom_range(0, 3) != 0 && tbl_up[k] && !tbl_dflt[k])
         return tbl_dest[k] | ($urandom & ~tbl_mask[k]);
      return $urandom;
   endfunction

   // mostly a slot that holds a reference
   function automatic logic [3:0] pick_release_slot();
      int k;
      k = $urandom_range(0, SLOTS - 1);
      if ($urandom_range(0, 9) < 7)
         for (int i = 0; i < SLOTS; i++)
            if (tbl_refs[(k + i) % SLOTS] != 0)
               return 4'((k + i) % SLOTS);
      return 4'(k);
   endfunction

   function automatic route_cmd_type gen_random_cmd(int n);
      route_cmd_type c;
      int r;
      int plen;
      c.addr   = $urandom;
      c.mask   = $urandom;
      c.iface  = 4'($urandom_range(0, 15));
      c.slot   = 4'($urandom_range(0, 15));
      c.pinned = 1'b0;
      c.want   = NO_PIN;
      r = $urandom_range(0, 99);
      if (n >= HOT_FIRST && n < HOT_LAST) begin
         // hammer one route so its count reaches saturation
         if (r < 88) begin
            c.op = OP_LOOKUP;
            c.addr = hot_addr;
         end else if (r < 94) begin
            c.op = OP_LOOKUP;
            c.addr = pick_lookup_addr();
         end else begin
            c.op = OP_RELEASE;
            c.slot = pick_release_slot();
         end
      end else if (r < ((n < HOT_FIRST) ? 24 : 10)) begin
         c.op = (r % 4 == 0) ? OP_ADD_DEFAULT : OP_ADD_ROUTE;
         plen = ($urandom_range(0, 39) == 0) ? 0 : $urandom_range(1, 32);
         c.mask = 32'hFFFF_FFFF << (32 - plen);
         if ($urandom_range(0, 5) != 0)
            c.addr = c.addr & c.mask;
      end else if (r < ((n < HOT_FIRST) ? 70 : 55)) begin
         c.op = OP_LOOKUP;
         c.addr = ($urandom_range(0, 9) < 3 && n >= HOT_LAST) ? hot_addr : pick_lookup_addr();
      end else begin
         c.op = OP_RELEASE;
         c.slot = (n >= HOT_LAST && $urandom_range(0, 1) == 0) ? 4'(hot_slot)
                                                               : pick_release_slot();
      end
      return c;
   endfunction

   // drive at a falling edge, return at the falling edge after the accepting beat
   task automatic send_cmd(input route_cmd_type c);
      start         <= 1'b1;
      req_op        <= c.op;
      req_dest_addr <= c.addr;
      req_net_mask  <= c.mask;
      req_iface_id  <= c.iface;
      req_slot_in   <= c.slot;
      pin_valid     <= c.pinned;
      pin_rsp       <= c.want;
      do
         @(posedge clock);
      while (busy);
      @(negedge clock);
   endtask

   task automatic maybe_idle();
      int gap;
      if ($urandom_range(0, 3) == 0) begin
         gap = $urandom_range(1, 18);
         start <= 1'b0;
         repeat (gap) @(negedge clock);
      end
   endtask

   initial begin
      route_cmd_type cmd;
      reset         = 1'b1;
      start         = 1'b0;
      req_op        = OP_LOOKUP;
      req_dest_addr = '0;
      req_net_mask  = '0;
      req_iface_id  = '0;
      req_slot_in   = '0;
      pin_valid     = 1'b0;
      pin_rsp       = NO_PIN;
      for (int i = 0; i < SLOTS; i++) begin
         tbl_up[i]    = 1'b0;
         tbl_dflt[i]  = 1'b0;
         tbl_dest[i]  = '0;
         tbl_mask[i]  = '0;
         tbl_iface[i] = '0;
         tbl_refs[i]  = '0;
      end
      dir_tab = '{
         // empty table: no route, releases have nothing to drop
         '{OP_LOOKUP,      32'hC0A8_0001, 32'hFFFF_FFFF, 4'h0, 4'h0, 1'b1,
           '{STAT_NOROUTE, 4'd0, 4'd0, 1'b0}},
         '{OP_RELEASE,     32'h0000_0000, 32'h0000_0000, 4'h0, 4'h0, 1'b1,
           '{STAT_UNREF, 4'd0, 4'd0, 1'b0}},
         '{OP_RELEASE,     32'hFFFF_FFFF, 32'hFFFF_FFFF, 4'hF, 4'hF, 1'b1,
           '{STAT_UNREF, 4'd15, 4'd0, 1'b0}},
         '{OP_ADD_ROUTE,   32'h0A00_0000, 32'hFF00_0000, 4'h3, 4'h0, 1'b1,
           '{STAT_OK, 4'd0, 4'd0, 1'b0}},
         // mask must be dropped for a default
         '{OP_ADD_DEFAULT, 32'h1234_5678, 32'hFFFF_FFFF, 4'hF, 4'h5, 1'b1,
           '{STAT_OK, 4'd1, 4'd0, 1'b0}},
         // host bits set outside the mask: never matches
         '{OP_ADD_ROUTE,   32'hC0A8_0101, 32'hFFFF_FF00, 4'h5, 4'h0, 1'b1,
           '{STAT_OK, 4'd2, 4'd0, 1'b0}},
         '{OP_ADD_ROUTE,   32'hFFFF_FFFF, 32'hFFFF_FFFF, 4'h0, 4'h0, 1'b1,
           '{STAT_OK, 4'd3, 4'd0, 1'b0}},
         '{OP_LOOKUP,      32'h0A0B_0C0D, 32'h0000_0000, 4'h0, 4'h0, 1'b0, NO_PIN},
         '{OP_LOOKUP,      32'hC0A8_0101, 32'h0000_0000, 4'h0, 4'h0, 1'b0, NO_PIN},
         '{OP_LOOKUP,      32'hFFFF_FFFF, 32'hFFFF_FFFF, 4'hF, 4'hF, 1'b0, NO_PIN},
         '{OP_ADD_DEFAULT, 32'h0000_0000, 32'h0000_0000, 4'h9, 4'h0, 1'b1,
           '{STAT_OK, 4'd4, 4'd0, 1'b0}},
         // two defaults: the later one serves a miss
         '{OP_LOOKUP,      32'h0000_0000, 32'h0000_0000, 4'h0, 4'h0, 1'b0, NO_PIN},
         '{OP_ADD_ROUTE,   32'hC0A8_0000, 32'hFFFF_0000, 4'hA, 4'h0, 1'b1,
           '{STAT_OK, 4'd5, 4'd0, 1'b0}},
         '{OP_LOOKUP,      32'hC0A8_FFFF, 32'h0000_0000, 4'h0, 4'h0, 1'b0, NO_PIN},
         '{OP_RELEASE,     32'h0000_0000, 32'h0000_0000, 4'h0, 4'h0, 1'b0, NO_PIN},
         '{OP_RELEASE,     32'h0000_0000, 32'h0000_0000, 4'h0, 4'h0, 1'b0, NO_PIN},
         '{OP_RELEASE,     32'h0000_0000, 32'h0000_0000, 4'h0, 4'h4, 1'b0, NO_PIN},
         '{OP_RELEASE,     32'h0000_0000, 32'h0000_0000, 4'h0, 4'h2, 1'b0, NO_PIN},
         // more specific route behind a wider one: first match still wins
         '{OP_ADD_ROUTE,   32'h0A01_0000, 32'hFFFF_0000, 4'hC, 4'h0, 1'b0, NO_PIN},
         '{OP_LOOKUP,      32'h0A01_0203, 32'h0000_0000, 4'h0, 4'h0, 1'b0, NO_PIN}
      };

      repeat (8) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      for (int n = 0; n < DIR_ROWS; n++) begin
         send_cmd(dir_tab[n]);
         maybe_idle();
      end

      for (int n = 0; n < RAND_ITEMS; n++) begin
         if (n == HOT_FIRST) begin
            hot_slot = 0;
            for (int i = SLOTS - 1; i >= 0; i--)
               if (tbl_up[i] && !tbl_dflt[i] && (tbl_dest[i] & ~tbl_mask[i]) == 0)
                  hot_slot = i;
            hot_addr = tbl_dest[hot_slot] | ($urandom & ~tbl_mask[hot_slot]);
         end
         cmd = gen_random_cmd(n);
         send_cmd(cmd);
         if (n < RAND_ITEMS - QUIET_ITEMS)
            maybe_idle();
      end
      start <= 1'b0;

      while (pending_rsp_q.size() != 0)
         @(posedge clock);
      repeat (TAIL_CYCLES) @(posedge clock);
      if (mismatch_cnt == 0)
         $display("Simulation PASSED");
      else
         $display("Simulation FAILED");
      $finish;
   end

endmodule
